@@ hdl/swm_pkg.sv @@
`default_nettype none
package swm_pkg;

    // Register index / byte address of window_len
    localparam int unsigned REG_WINDOW_LEN = 0;
    localparam int unsigned CFG_ADDR_W     = 3;
    localparam int unsigned CFG_DATA_W     = 32;
    localparam int unsigned WLEN_W         = 7;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd3;

    // Broadcast control from the top level to every cell
    typedef struct packed {
        logic step;   // a sample transfer updates the row this cycle
        logic clear;  // window_len write: drop every held sample
        logic full;   // window is full, this step evicts the oldest sample
    } swm_ctl_t;

endpackage
`default_nettype wire

@@ hdl/swm_cell.sv @@
`default_nettype none
module swm_cell
    import swm_pkg::*;
#(
    parameter int unsigned W  = 32,
    parameter int unsigned AW = 6
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire swm_ctl_t            ctl,
    input  wire logic signed [W-1:0] key,
    input  wire logic [AW-1:0]       last_age,
    // raw contents of the right neighbor
    input  wire logic signed [W-1:0] rt_val,
    input  wire logic [AW-1:0]       rt_age,
    input  wire logic                rt_valid,
    // compacted contents of the left neighbor
    input  wire logic signed [W-1:0] lf_val,
    input  wire logic [AW-1:0]       lf_age,
    input  wire logic                lf_valid,
    input  wire logic                lf_stay,
    input  wire logic                ge_in,
    output logic signed [W-1:0]      raw_val,
    output logic [AW-1:0]            raw_age,
    output logic                     raw_valid,
    output logic signed [W-1:0]      c_val,
    output logic [AW-1:0]            c_age,
    output logic                     c_valid,
    output logic                     stay,
    output logic                     ge_out
);

    logic signed [W-1:0] val_reg, val_next;
    logic [AW-1:0]       age_reg, age_next;
    logic                valid_reg, valid_next;
    logic                rm;

    // This cell holds the oldest sample and it leaves the window.
    assign rm     = valid_reg && ctl.full && (age_reg == last_age);
    assign ge_out = ge_in | rm;

    // Row as it looks with the evicted entry squeezed out
    assign c_val   = ge_out ? rt_val   : val_reg;
    assign c_age   = ge_out ? rt_age   : age_reg;
    assign c_valid = ge_out ? rt_valid : valid_reg;
    assign stay    = c_valid && (c_val <= key);

    always_comb begin
        val_next   = val_reg;
        age_next   = age_reg;
        valid_next = valid_reg;
        if (ctl.clear) begin
            valid_next = 1'b0;
        end else if (ctl.step) begin
            if (stay) begin
                val_next   = c_val;
                age_next   = c_age + 1'b1;
                valid_next = 1'b1;
            end else if (lf_stay) begin
                // insertion point
                val_next   = key;
                age_next   = '0;
                valid_next = 1'b1;
            end else begin
                // shift up by one to make room
                val_next   = lf_val;
                age_next   = lf_age + 1'b1;
                valid_next = lf_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        val_reg <= val_next;
        age_reg <= age_next;
    end

    assign raw_val   = val_reg;
    assign raw_age   = age_reg;
    assign raw_valid = valid_reg;

endmodule
`default_nettype wire

@@ hdl/sliding_window_median.sv @@
// Running lower-median filter over a stream of signed samples.
//
// Input channel (s_*): one sample per transfer in s_tdata. Output channel
// (m_*): one median per transfer in m_tdata. Config port (APB): register
// window_len at byte address 0 (1..WINDOW_MAX, 0 acts as 1, larger values
// act as WINDOW_MAX). A write restarts filling; write only while idle.
//
// The samples sit in a row of WINDOW_MAX cells kept in ascending order.
// Each sample transfer evicts the oldest entry (by age tag) and inserts the
// new sample in the same row update; every cell only looks at its two neighbors.
// The first window_len-1 samples after reset or a window_len write give no
// result; after that every sample yields one median.
//
// Output path: a sample transfer that gives a result sets a pending flag;
// once the output register is free the median is loaded into it and offered.
// Throughput: one sample per clock, set by the row update;
// s_tready drops only while a median waits, the output register is still
// full and m_tready is low, so a stalled receiver stalls the input.
// Reset (aresetn, synchronous) empties the row and sets window_len to 3.
`default_nettype none
module sliding_window_median
    import swm_pkg::*;
#(
    parameter int unsigned WINDOW_MAX   = 64,
    parameter int unsigned SAMPLE_WIDTH = 32,
    localparam int unsigned TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // s_tdata: [SAMPLE_WIDTH-1:0] sample, rest zero
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [TDATA_W-1:0]    s_tdata,
    // m_tdata: [SAMPLE_WIDTH-1:0] median, rest zero
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [TDATA_W-1:0]         m_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int unsigned AW      = $clog2(WINDOW_MAX);
    localparam int unsigned LEN_W   = $clog2(WINDOW_MAX + 1);

    // ---------------- configuration ----------------
    logic [WLEN_W-1:0] wlen_reg, wlen_next;
    logic              cfg_wr;
    logic [LEN_W-1:0]  len_eff;
    logic [AW-1:0]     last_age;
    logic [AW-1:0]     mid_idx;

    assign pready = 1'b1;
    // decode on the word address, byte lanes ignored
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[CFG_ADDR_W-1:2] == (CFG_ADDR_W-2)'(REG_WINDOW_LEN));
    assign prdata = (paddr[CFG_ADDR_W-1:2] == (CFG_ADDR_W-2)'(REG_WINDOW_LEN)) ?
                    CFG_DATA_W'(wlen_reg) : '0;

    always_comb begin
        wlen_next = wlen_reg;
        if (cfg_wr) begin
            wlen_next = pwdata[WLEN_W-1:0];
        end
    end

    always_comb begin
        if (wlen_reg == '0) begin
            len_eff = LEN_W'(1);
        end else if (32'(wlen_reg) > 32'(WINDOW_MAX)) begin
            len_eff = LEN_W'(WINDOW_MAX);
        end else begin
            len_eff = LEN_W'(wlen_reg);
        end
    end

    assign last_age = AW'(len_eff - 1'b1);
    assign mid_idx  = AW'((len_eff - 1'b1) >> 1);

    // ---------------- fill tracking and handshake ----------------
    logic [LEN_W-1:0] fill_reg, fill_next;
    logic             pend_reg, pend_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_WIDTH-1:0] median_reg;
    logic             out_free, load, s_xfer, full, gives_result;
    swm_ctl_t         ctl;

    assign out_free     = !m_tvalid_reg || m_tready;
    assign load         = pend_reg && out_free;
    assign s_tready     = !pend_reg || out_free;
    assign s_xfer       = s_tvalid && s_tready;
    assign full         = (fill_reg == len_eff);
    assign gives_result = full || ((fill_reg + 1'b1) == len_eff);

    assign ctl = '{step: s_xfer, clear: cfg_wr, full: full};

    always_comb begin
        fill_next = fill_reg;
        if (cfg_wr) begin
            fill_next = '0;
        end else if (s_xfer && !full) begin
            fill_next = fill_reg + 1'b1;
        end
    end

    always_comb begin
        pend_next = pend_reg;
        if (s_xfer && gives_result) begin
            pend_next = 1'b1;
        end else if (load) begin
            pend_next = 1'b0;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // ---------------- sorted cell row ----------------
    logic signed [SAMPLE_WIDTH-1:0] key;
    logic signed [SAMPLE_WIDTH-1:0] raw_val [WINDOW_MAX];
    logic [AW-1:0]                  raw_age [WINDOW_MAX];
    logic                           raw_valid [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] c_val [WINDOW_MAX];
    logic [AW-1:0]                  c_age [WINDOW_MAX];
    logic                           c_valid [WINDOW_MAX];
    logic                           stay [WINDOW_MAX];
    logic                           ge [WINDOW_MAX];

    assign key = $signed(s_tdata[SAMPLE_WIDTH-1:0]);

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        logic signed [SAMPLE_WIDTH-1:0] rt_val, lf_val;
        logic [AW-1:0]                  rt_age, lf_age;
        logic                           rt_valid, lf_valid, lf_stay, ge_in;

        if (i == WINDOW_MAX - 1) begin : g_last
            assign rt_val   = '0;
            assign rt_age   = '0;
            assign rt_valid = 1'b0;
        end else begin : g_mid
            assign rt_val   = raw_val[i+1];
            assign rt_age   = raw_age[i+1];
            assign rt_valid = raw_valid[i+1];
        end

        if (i == 0) begin : g_first
            // left of the row counts as "below the key"
            assign lf_val   = '0;
            assign lf_age   = '0;
            assign lf_valid = 1'b0;
            assign lf_stay  = 1'b1;
            assign ge_in    = 1'b0;
        end else begin : g_rest
            assign lf_val   = c_val[i-1];
            assign lf_age   = c_age[i-1];
            assign lf_valid = c_valid[i-1];
            assign lf_stay  = stay[i-1];
            assign ge_in    = ge[i-1];
        end

        swm_cell #(
            .W  (SAMPLE_WIDTH),
            .AW (AW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctl       (ctl),
            .key       (key),
            .last_age  (last_age),
            .rt_val    (rt_val),
            .rt_age    (rt_age),
            .rt_valid  (rt_valid),
            .lf_val    (lf_val),
            .lf_age    (lf_age),
            .lf_valid  (lf_valid),
            .lf_stay   (lf_stay),
            .ge_in     (ge_in),
            .raw_val   (raw_val[i]),
            .raw_age   (raw_age[i]),
            .raw_valid (raw_valid[i]),
            .c_val     (c_val[i]),
            .c_age     (c_age[i]),
            .c_valid   (c_valid[i]),
            .stay      (stay[i]),
            .ge_out    (ge[i])
        );
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg     <= WLEN_RESET;
            fill_reg     <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            wlen_reg     <= wlen_next;
            fill_reg     <= fill_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        // the row already holds the post-update window when load is high
        if (load) begin
            median_reg <= raw_val[mid_idx];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(median_reg);

endmodule
`default_nettype wire
